// File: design/mrm_pkg.sv
// ----------------------------------------------------------------------------
// mrm_pkg: shared types and constants for the 4x4 row multiplier
// Field widths, stream packing and control structs used by every module.
// ----------------------------------------------------------------------------
package mrm_pkg;

  // Matrix order; one lane per result column
  localparam int NUM_LANES = 4;
  localparam int ROW_W     = 2;

  // Fixed element field width on the stream ports
  localparam int FIELD_W = 32;

  // Row tag plus four elements, padded to whole bytes
  localparam int PAYLOAD_W = ROW_W + NUM_LANES * FIELD_W;
  localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

  // Defaults for the top-level parameters
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MUL  = 1'b1
  } cmd_t;

  // Per-lane register enables
  typedef struct packed {
    logic prod_en;
    logic pair_en;
  } lane_ctl_t;

endpackage

// File: design/mrm_store.sv
// ----------------------------------------------------------------------------
// mrm_store: right-hand matrix storage
// Sixteen elements, one whole row written per load transfer, all readable.
// ----------------------------------------------------------------------------
module mrm_store #(
  parameter int ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  wr_en,
  input  logic [mrm_pkg::ROW_W-1:0]                             wr_row,
  input  logic [mrm_pkg::NUM_LANES-1:0][ELEM_WIDTH-1:0]         wr_data,
  output logic [mrm_pkg::NUM_LANES-1:0][mrm_pkg::NUM_LANES-1:0][ELEM_WIDTH-1:0] mat
);

  logic [mrm_pkg::NUM_LANES-1:0][mrm_pkg::NUM_LANES-1:0][ELEM_WIDTH-1:0] mat_r;
  logic [mrm_pkg::NUM_LANES-1:0][mrm_pkg::NUM_LANES-1:0][ELEM_WIDTH-1:0] mat_nxt;

  always_comb begin
    mat_nxt = mat_r;
    if (wr_en) begin
      mat_nxt[wr_row] = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= '0;
    end else begin
      mat_r <= mat_nxt;
    end
  end

  assign mat = mat_r;

endmodule

// File: design/mrm_lane.sv
// ----------------------------------------------------------------------------
// mrm_lane: one result column
// Four products, pairwise sums, final sum with shift and saturation.
// ----------------------------------------------------------------------------
module mrm_lane #(
  parameter int ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mrm_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  mrm_pkg::lane_ctl_t                            ctl,
  input  logic [mrm_pkg::NUM_LANES-1:0][ELEM_WIDTH-1:0] row_elem,
  input  logic [mrm_pkg::NUM_LANES-1:0][ELEM_WIDTH-1:0] col_elem,
  output logic [mrm_pkg::FIELD_W-1:0]                   result,
  output logic                                          sat
);

  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  logic signed [PROD_W-1:0] prod_r   [mrm_pkg::NUM_LANES];
  logic signed [PROD_W-1:0] prod_nxt [mrm_pkg::NUM_LANES];
  logic signed [PAIR_W-1:0] pair_r   [2];
  logic signed [PAIR_W-1:0] pair_nxt [2];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;
  logic [SUM_W-ELEM_WIDTH:0] top_bits;
  logic                      fits;
  logic signed [ELEM_WIDTH-1:0] res_ew;

  always_comb begin
    for (int k = 0; k < mrm_pkg::NUM_LANES; k++) begin
      prod_nxt[k] = PROD_W'($signed(row_elem[k])) * PROD_W'($signed(col_elem[k]));
    end
    pair_nxt[0] = PAIR_W'(prod_r[0]) + PAIR_W'(prod_r[1]);
    pair_nxt[1] = PAIR_W'(prod_r[2]) + PAIR_W'(prod_r[3]);
  end

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.pair_en) begin
      pair_r <= pair_nxt;
    end
  end

  // Exact sum, floor shift, then clamp to the element range
  always_comb begin
    sum      = SUM_W'(pair_r[0]) + SUM_W'(pair_r[1]);
    shifted  = sum >>> FRAC_BITS;
    top_bits = shifted[SUM_W-1:ELEM_WIDTH-1];
    fits     = (&top_bits) || !(|top_bits);
    if (fits) begin
      res_ew = shifted[ELEM_WIDTH-1:0];
    end else if (shifted[SUM_W-1]) begin
      res_ew = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
    end else begin
      res_ew = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    end
    result = mrm_pkg::FIELD_W'(res_ew);
    sat    = !fits;
  end

endmodule

// File: design/mrm_merge.sv
// ----------------------------------------------------------------------------
// mrm_merge: result row assembly and output register
// Packs the lane results with the row tag, ORs the saturation flags.
// ----------------------------------------------------------------------------
module mrm_merge (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    s_valid,
  output logic                                                    s_ready,
  input  logic [mrm_pkg::ROW_W-1:0]                               s_row,
  input  logic [mrm_pkg::NUM_LANES-1:0][mrm_pkg::FIELD_W-1:0]     s_result,
  input  logic [mrm_pkg::NUM_LANES-1:0]                           s_sat,
  output logic                                                    out_tvalid,
  input  logic                                                    out_tready,
  output logic [mrm_pkg::TDATA_W-1:0]                             out_tdata,
  output logic                                                    out_tuser
);

  logic                              valid_r;
  logic                              valid_nxt;
  logic [mrm_pkg::TDATA_W-1:0]       data_r;
  logic                              clip_r;
  logic                              take;

  assign s_ready = !valid_r || out_tready;
  assign take    = s_valid && s_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (s_ready) begin
      valid_nxt = s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= mrm_pkg::TDATA_W'({s_result, s_row});
      clip_r <= |s_sat;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = clip_r;

endmodule

// File: design/matrix4_row_multiply.sv
// ----------------------------------------------------------------------------
// matrix4_row_multiply: 4x4 fixed-point matrix product, one row per transfer
// Load transfers write a row of the stored right-hand matrix; multiply
// transfers return the product row, shifted by FRAC_BITS and saturated.
// ----------------------------------------------------------------------------
//  Channel  Dir  Signals                 Contents
//  in_      in   tvalid/tready/tdata     tdata: row_index, elem_a..elem_d
//                tuser                   tuser: cmd (0 load, 1 multiply)
//  out_     out  tvalid/tready/tdata     tdata: out_row, prod_a..prod_d
//                tuser                   tuser: clipped
//
//  One transfer per cycle in and out while out_tready stays high. A multiply row
//  reaches out_ through the product register, the pairwise sum register, then
//  the output register after the final sum and saturation.
//  A load is seen by the very next multiply.
//  Synchronous active-low reset empties the pipeline and zeroes the matrix.
//  A stall on out_ fills the bubbles first, then backs up to in_tready.
// ----------------------------------------------------------------------------
module matrix4_row_multiply #(
  parameter int ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mrm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [1:0] row_index, [33:2] elem_a, [65:34] elem_b, [97:66] elem_c,
  // [129:98] elem_d, [135:130] zero
  input  logic [mrm_pkg::TDATA_W-1:0] in_tdata,
  // [0] cmd
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [1:0] out_row, [33:2] prod_a, [65:34] prod_b, [97:66] prod_c,
  // [129:98] prod_d, [135:130] zero
  output logic [mrm_pkg::TDATA_W-1:0] out_tdata,
  // [0] clipped
  output logic                        out_tuser
);

  localparam int NL = mrm_pkg::NUM_LANES;

  logic                              accept;
  logic                              mul_take;
  logic                              load_take;
  logic [mrm_pkg::ROW_W-1:0]         in_row;
  logic [NL-1:0][ELEM_WIDTH-1:0]     in_elem;
  logic [NL-1:0][NL-1:0][ELEM_WIDTH-1:0] mat;
  logic [NL-1:0][ELEM_WIDTH-1:0]     col [NL];
  logic [NL-1:0][mrm_pkg::FIELD_W-1:0] lane_res;
  logic [NL-1:0]                     lane_sat;
  mrm_pkg::lane_ctl_t                ctl;

  logic                              prod_v_r;
  logic                              prod_v_nxt;
  logic                              pair_v_r;
  logic                              pair_v_nxt;
  logic [mrm_pkg::ROW_W-1:0]         prod_row_r;
  logic [mrm_pkg::ROW_W-1:0]         pair_row_r;
  logic                              merge_ready;
  logic                              pair_ready;
  logic                              prod_ready;

  // Stage handshakes: each stage frees up when empty or moving on
  assign pair_ready = !pair_v_r || merge_ready;
  assign prod_ready = !prod_v_r || pair_ready;
  assign in_tready  = prod_ready;
  assign accept     = in_tvalid && in_tready;
  assign mul_take   = accept && (mrm_pkg::cmd_t'(in_tuser) == mrm_pkg::CMD_MUL);
  assign load_take  = accept && (mrm_pkg::cmd_t'(in_tuser) == mrm_pkg::CMD_LOAD);

  assign ctl.prod_en = mul_take;
  assign ctl.pair_en = prod_v_r && pair_ready;

  assign in_row = in_tdata[mrm_pkg::ROW_W-1:0];

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      in_elem[k] = in_tdata[mrm_pkg::ROW_W + k*mrm_pkg::FIELD_W +: ELEM_WIDTH];
    end
    for (int j = 0; j < NL; j++) begin
      for (int k = 0; k < NL; k++) begin
        col[j][k] = mat[k][j];
      end
    end
  end

  always_comb begin
    prod_v_nxt = prod_v_r;
    pair_v_nxt = pair_v_r;
    if (prod_ready) begin
      prod_v_nxt = mul_take;
    end
    if (pair_ready) begin
      pair_v_nxt = prod_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      pair_v_r <= 1'b0;
    end else begin
      prod_v_r <= prod_v_nxt;
      pair_v_r <= pair_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_row_r <= in_row;
    end
    if (ctl.pair_en) begin
      pair_row_r <= prod_row_r;
    end
  end

  mrm_store #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (load_take),
    .wr_row  (in_row),
    .wr_data (in_elem),
    .mat     (mat)
  );

  for (genvar j = 0; j < NL; j++) begin : g_lane
    mrm_lane #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .row_elem (in_elem),
      .col_elem (col[j]),
      .result   (lane_res[j]),
      .sat      (lane_sat[j])
    );
  end

  mrm_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_valid    (pair_v_r),
    .s_ready    (merge_ready),
    .s_row      (pair_row_r),
    .s_result   (lane_res),
    .s_sat      (lane_sat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_take |=> !prod_v_r)
    else $error("load transfer entered the product stage");

  a_mul_enters: assert property (@(posedge clk) disable iff (!rst_n)
    mul_take |=> prod_v_r)
    else $error("multiply transfer lost at the product stage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_v_r && pair_v_r && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while the pipeline is full and stalled");

  a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_v_r && !in_tready) |=> prod_v_r && $stable(prod_row_r))
    else $error("stalled product stage dropped or changed its row");

endmodule

// File: sim/mrm_checker.sv
// ----------------------------------------------------------------------------
// mrm_checker: stream checker for the 4x4 row multiplier
// Watches both channels, keeps its own copy of the right-hand matrix, works out
// each product row on input transfers and compares result transfers in order.
// ----------------------------------------------------------------------------
module mrm_checker #(
  parameter int ELEM_WIDTH = mrm_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mrm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [mrm_pkg::TDATA_W-1:0] in_tdata,
  input  logic                        in_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [mrm_pkg::TDATA_W-1:0] out_tdata,
  input  logic                        out_tuser,
  output int                          mismatches,
  output int                          outstanding
);

  typedef struct packed {
    logic [1:0]       row;
    logic [3:0][31:0] prod;
    logic             clip;
  } prod_row_t;

  // Right-hand matrix, rows by columns, elements already sign-extended
  logic [31:0] rhs_mat [4][4];
  prod_row_t   pending_rows[$];

  function automatic logic signed [31:0] to_elem(logic [31:0] raw);
    return $signed(raw << (32 - ELEM_WIDTH)) >>> (32 - ELEM_WIDTH);
  endfunction

  function automatic prod_row_t row_product(logic [1:0] row, logic [3:0][31:0] lhs);
    prod_row_t          r;
    logic signed [67:0] acc;
    logic signed [67:0] lim_hi;
    logic signed [67:0] lim_lo;
    lim_hi = (68'sd1 <<< (ELEM_WIDTH - 1)) - 68'sd1;
    lim_lo = -(68'sd1 <<< (ELEM_WIDTH - 1));
    r.row  = row;
    r.clip = 1'b0;
    for (int j = 0; j < 4; j++) begin
      acc = '0;
      // exact sum, no wrap: 68 bits hold four 64-bit products
      for (int k = 0; k < 4; k++) begin
        acc = acc + to_elem(lhs[k]) * $signed(rhs_mat[k][j]);
      end
      acc = acc >>> FRAC_BITS;
      if (acc > lim_hi) begin
        r.prod[j] = lim_hi[31:0];
        r.clip    = 1'b1;
      end else if (acc < lim_lo) begin
        r.prod[j] = lim_lo[31:0];
        r.clip    = 1'b1;
      end else begin
        r.prod[j] = acc[31:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    int               errs;
    prod_row_t        want;
    logic [1:0]       row;
    logic [3:0][31:0] lhs;
    logic [31:0]      got;
    errs = 0;
    if (!rst_n) begin
      foreach (rhs_mat[r, c]) rhs_mat[r][c] = '0;
      pending_rows.delete();
      outstanding <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        row = in_tdata[1:0];
        lhs = in_tdata[129:2];
        if (mrm_pkg::cmd_t'(in_tuser) == mrm_pkg::CMD_LOAD) begin
          for (int j = 0; j < 4; j++) rhs_mat[row][j] = to_elem(lhs[j]);
        end else begin
          pending_rows.push_back(row_product(row, lhs));
        end
      end
      if (out_tvalid && out_tready) begin
        if (pending_rows.size() == 0) begin
          $display("%0t: unexpected result, expected none, got row %0d data %h clipped %b",
                   $time, out_tdata[1:0], out_tdata[129:2], out_tuser);
          errs++;
        end else begin
          want = pending_rows.pop_front();
          if (out_tdata[1:0] !== want.row) begin
            $display("%0t: out_row expected %0d got %0d", $time, want.row, out_tdata[1:0]);
            errs++;
          end
          for (int j = 0; j < 4; j++) begin
            got = out_tdata[2 + 32 * j +: 32];
            if (got !== want.prod[j]) begin
              $display("%0t: row %0d column %0d expected %h got %h",
                       $time, want.row, j, want.prod[j], got);
              errs++;
            end
          end
          if (out_tuser !== want.clip) begin
            $display("%0t: row %0d clipped expected %b got %b",
                     $time, want.row, want.clip, out_tuser);
            errs++;
          end
        end
      end
      outstanding <= pending_rows.size();
    end
    mismatches <= mismatches + errs;
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for matrix4_row_multiply
// Drives directed then random load and multiply rows through several idle
// and stall phases; the checker predicts every product row and counts errors.
// ----------------------------------------------------------------------------
module tb;

  localparam int RESET_CYCLES = 7;
  localparam int PHASE_ITEMS  = 230;
  localparam int NUM_PHASES   = 5;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [31:0] RAW_M1 = 32'hffff_ffff;
  localparam logic [31:0] RAW_1  = 32'h0000_0001;

  typedef enum int {MAG_SMALL, MAG_MED, MAG_FULL, MAG_CORNER} mag_t;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_tvalid  = 1'b0;
  logic [mrm_pkg::TDATA_W-1:0] in_tdata   = '0;
  logic                        in_tuser   = 1'b0;
  logic                        out_tready = 1'b0;
  logic                        in_tready;
  logic                        out_tvalid;
  logic [mrm_pkg::TDATA_W-1:0] out_tdata;
  logic                        out_tuser;

  int mismatches;
  int outstanding;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;

  int phase_idle  [NUM_PHASES] = '{0, 85, 0, 38, 0};
  int phase_stall [NUM_PHASES] = '{0, 0, 85, 38, 0};

  matrix4_row_multiply dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  mrm_checker row_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
    cycles     <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Call at a rising edge; returns at the edge of the transfer
  task automatic send_row(input mrm_pkg::cmd_t cmd, input logic [1:0] row,
                          input logic [31:0] a, input logic [31:0] b,
                          input logic [31:0] c, input logic [31:0] d);
    logic rdy;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= mrm_pkg::TDATA_W'({d, c, b, a, row});
    // sample ready mid-cycle, once inputs have settled
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
  endtask

  function automatic logic [31:0] rand_elem(mag_t mag);
    case (mag)
      MAG_SMALL: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      MAG_MED:   return 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
      MAG_FULL:  return $urandom;
      default: begin
        case ($urandom_range(0, 6))
          0:       return '0;
          1:       return RAW_1;
          2:       return RAW_M1;
          3:       return Q_MAX;
          4:       return Q_MIN;
          5:       return Q_ONE;
          default: return -Q_ONE;
        endcase
      end
    endcase
  endfunction

  task automatic random_row();
    int               pick;
    mag_t             row_mag;
    logic             mixed;
    logic [3:0][31:0] e;
    mrm_pkg::cmd_t    cmd;
    pick    = $urandom_range(0, 99);
    mixed   = (pick >= 80);
    row_mag = pick < 45 ? MAG_SMALL : pick < 60 ? MAG_MED : pick < 72 ? MAG_FULL : MAG_CORNER;
    for (int j = 0; j < 4; j++) begin
      e[j] = rand_elem(mixed ? mag_t'($urandom_range(0, 3)) : row_mag);
    end
    cmd = ($urandom_range(0, 99) < 25) ? mrm_pkg::CMD_LOAD : mrm_pkg::CMD_MUL;
    send_row(cmd, 2'($urandom_range(0, 3)), e[0], e[1], e[2], e[3]);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // matrix still zero after reset
    send_row(mrm_pkg::CMD_MUL,  2'd0, 32'd1, 32'd2, 32'd3, 32'd4);
    // identity passes the extremes through unchanged
    send_row(mrm_pkg::CMD_LOAD, 2'd0, Q_ONE, '0, '0, '0);
    send_row(mrm_pkg::CMD_LOAD, 2'd1, '0, Q_ONE, '0, '0);
    send_row(mrm_pkg::CMD_LOAD, 2'd2, '0, '0, Q_ONE, '0);
    send_row(mrm_pkg::CMD_LOAD, 2'd3, '0, '0, '0, Q_ONE);
    send_row(mrm_pkg::CMD_MUL,  2'd1, Q_MAX, Q_MIN, RAW_M1, RAW_1);
    send_row(mrm_pkg::CMD_MUL,  2'd2, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    // saturate high and low
    send_row(mrm_pkg::CMD_LOAD, 2'd3, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_row(mrm_pkg::CMD_MUL,  2'd3, '0, '0, '0, Q_MAX);
    send_row(mrm_pkg::CMD_MUL,  2'd0, '0, '0, '0, Q_MIN);
    // huge partial products cancel back into range
    send_row(mrm_pkg::CMD_LOAD, 2'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_row(mrm_pkg::CMD_MUL,  2'd1, Q_MIN, '0, '0, Q_MIN);
    // shift rounds toward minus infinity
    send_row(mrm_pkg::CMD_LOAD, 2'd1, RAW_1, RAW_1, RAW_1, RAW_1);
    send_row(mrm_pkg::CMD_LOAD, 2'd2, RAW_M1, RAW_M1, RAW_M1, RAW_M1);
    send_row(mrm_pkg::CMD_MUL,  2'd2, '0, RAW_1, '0, '0);
    send_row(mrm_pkg::CMD_MUL,  2'd3, '0, RAW_M1, '0, '0);
    send_row(mrm_pkg::CMD_MUL,  2'd0, '0, '0, RAW_1, '0);
    send_row(mrm_pkg::CMD_MUL,  2'd1, '0, '0, RAW_M1, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct <= phase_stall[p];
      repeat (PHASE_ITEMS) random_row();
    end

    in_tvalid <= 1'b0;
    stall_pct <= 0;
    // let the count catch up with the last transfer
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
